// ===== hw/rtl/tpvr_pkg.sv =====
// ----------------------------------------------------------------------------
// tpvr_pkg
// Shared types and constants of the text and pixel video renderer.
// ----------------------------------------------------------------------------
package tpvr_pkg;

    typedef enum logic [2:0] {
        REQ_RENDER    = 3'd0,
        REQ_FB        = 3'd1,
        REQ_CHAR      = 3'd2,
        REQ_ATTR      = 3'd3,
        REQ_TILE_ROW  = 3'd4,
        REQ_TILE_FLAG = 3'd5,
        REQ_FONT      = 3'd6,
        REQ_PALETTE   = 3'd7
    } t_req;

    // display modes; codes above MODE_T80_COLOUR behave as text40 mono
    localparam logic [2:0] MODE_PIXEL      = 3'd0;
    localparam logic [2:0] MODE_T40_MONO   = 3'd1;
    localparam logic [2:0] MODE_T40_COLOUR = 3'd2;
    localparam logic [2:0] MODE_T80_MONO   = 3'd3;
    localparam logic [2:0] MODE_T80_COLOUR = 3'd4;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_MODE = 1'b0;

    localparam int PIX_DEPTH   = 76800;
    localparam int MAP_DEPTH   = 4800;
    localparam int GLYPH_DEPTH = 2048;
    localparam int TILE_COUNT  = 256;
    localparam int PAL_DEPTH   = 256;
    localparam int QUEUE_DEPTH = 4;

    localparam int PIX_AW   = 17;
    localparam int MAP_AW   = 13;
    localparam int GLYPH_AW = 11;
    localparam int CODE_AW  = 8;

    localparam logic [7:0] ATTR_FG_MASK = 8'h07;
    localparam logic [7:0] ATTR_SWAP    = 8'h80;
    localparam logic [6:0] COLS_WIDE    = 7'd80;
    localparam logic [6:0] COLS_NARROW  = 7'd40;

    // one classified beat as it waits between front and back
    typedef struct packed {
        t_req        req;
        logic        blank;     // render outside the raster
        logic        pix_mode;
        logic        colour;
        logic        in_range;  // map or framebuffer index is valid
        logic [16:0] addr;
        logic [7:0]  value;
        logic [7:0]  code;
        logic [2:0]  line;      // glyph row, also sub-row of a render
        logic [2:0]  bitpos;
        logic [23:0] cword;
    } t_qent;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

// ===== hw/rtl/text_and_pixel_video_renderer.sv =====
// ----------------------------------------------------------------------------
// text_and_pixel_video_renderer
// Per-pixel raster renderer for an indexed framebuffer and 8x8 text modes.
//
//   channel   direction  handshake             beat contents
//   request   in         i_valid / o_stall     req_type, position, store data
//   pixel     out        o_valid / i_stall     red, green, blue
//   config    in         APB (psel..pready)    display_mode at byte address 0
//
// One beat per cycle sustained while i_stall is low; a render passes through
// the queue, map read, glyph read, palette read and output register.
// Reset starts a clearing pass over all stores, paced by the framebuffer
// depth; o_stall stays high during it.
// i_stall, while a pixel is held at the output, freezes the back pipeline;
// the four-entry queue keeps taking requests until it fills, then o_stall rises.
// ----------------------------------------------------------------------------
module text_and_pixel_video_renderer import tpvr_pkg::*; #(
    parameter int OUT_WIDTH  = 640,
    parameter int FB_COLS    = 320,
    parameter int OUT_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_pos_x,
    input  logic [8:0]  i_pos_y,
    input  logic [16:0] i_store_address,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_glyph_code,
    input  logic [2:0]  i_glyph_line,
    input  logic [23:0] i_colour_word,

    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       [2:0] r_mode;
    logic             cfg_wr;
    logic             busy;
    logic             push;
    logic             pop;
    t_qent            entry;
    t_qent            head;
    t_qstat           qstat;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_MODE);
    assign prdata = (paddr[2] == REG_IDX_MODE) ? {29'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_T40_MONO;
        end else if (cfg_wr) begin
            r_mode <= pwdata[2:0];
        end
    end

    assign o_stall = busy || qstat.full;
    assign push    = i_valid && !o_stall;

    tpvr_front #(
        .OUT_WIDTH  (OUT_WIDTH),
        .FB_COLS    (FB_COLS),
        .OUT_HEIGHT (OUT_HEIGHT)
    ) u_front (
        .i_mode          (r_mode),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_store_address (i_store_address),
        .i_byte_value    (i_byte_value),
        .i_glyph_code    (i_glyph_code),
        .i_glyph_line    (i_glyph_line),
        .i_colour_word   (i_colour_word),
        .o_entry         (entry)
    );

    tpvr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    tpvr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (!qstat.empty),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_busy       (busy)
    );

    // a synchronous reset always restarts the clearing pass
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("clearing pass not started by reset");

    // nothing is queued or delivered while the stores are being cleared
    a_quiet_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (!o_valid && qstat.empty))
        else $error("traffic during clearing pass");

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue reports full and empty together");

endmodule

// ===== hw/rtl/tpvr_ram.sv =====
// ----------------------------------------------------------------------------
// tpvr_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpvr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tpvr_front.sv =====
// ----------------------------------------------------------------------------
// tpvr_front
// Classifies an incoming beat: decodes the display mode, checks the raster,
// and forms the framebuffer or character map index of a render.
// ----------------------------------------------------------------------------
module tpvr_front import tpvr_pkg::*; #(
    parameter int OUT_WIDTH  = 640,
    parameter int FB_COLS    = 320,
    parameter int OUT_HEIGHT = 480
) (
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_pos_x,
    input  logic [8:0]  i_pos_y,
    input  logic [16:0] i_store_address,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_glyph_code,
    input  logic [2:0]  i_glyph_line,
    input  logic [23:0] i_colour_word,
    output t_qent       o_entry
);

    logic        in_raster;
    logic        pix_m;
    logic        wide;
    logic        colour_m;
    logic [8:0]  px_lx;
    logic [7:0]  px_ly;
    logic [18:0] px_idx;
    logic        px_ok;
    logic [9:0]  t_lx;
    logic [8:0]  t_ly;
    logic [6:0]  t_col;
    logic [5:0]  t_row;
    logic [6:0]  cols;
    logic [12:0] t_idx;
    logic        t_ok;
    logic        wr_ok;
    t_req        req;

    assign req = t_req'(i_req_type);

    always_comb begin
        pix_m    = 1'b0;
        wide     = 1'b0;
        colour_m = 1'b0;
        unique case (i_mode)
            MODE_PIXEL: begin
                pix_m = 1'b1;
            end
            MODE_T40_COLOUR: begin
                colour_m = 1'b1;
            end
            MODE_T80_MONO: begin
                wide = 1'b1;
            end
            MODE_T80_COLOUR: begin
                wide     = 1'b1;
                colour_m = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign in_raster = (11'(i_pos_x) < 11'(OUT_WIDTH)) && (10'(i_pos_y) < 10'(OUT_HEIGHT));

    // pixel mode: framebuffer doubled in both directions
    assign px_lx  = i_pos_x[9:1];
    assign px_ly  = i_pos_y[8:1];
    assign px_idx = 19'(px_ly) * 19'(FB_COLS) + 19'(px_lx);
    assign px_ok  = (10'(px_lx) < 10'(FB_COLS)) && (px_idx < 19'(PIX_DEPTH));

    // text modes: 8x8 cells, doubled in text40
    assign t_lx  = wide ? i_pos_x : {1'b0, i_pos_x[9:1]};
    assign t_ly  = wide ? i_pos_y : {1'b0, i_pos_y[8:1]};
    assign t_col = t_lx[9:3];
    assign t_row = t_ly[8:3];
    assign cols  = wide ? COLS_WIDE : COLS_NARROW;
    assign t_idx = 13'(t_row) * 13'(cols) + 13'(t_col);
    assign t_ok  = (t_col < cols) && (t_idx < 13'(MAP_DEPTH));

    always_comb begin
        case (req)
            REQ_FB:                wr_ok = i_store_address < 17'(PIX_DEPTH);
            REQ_CHAR, REQ_ATTR:    wr_ok = i_store_address < 17'(MAP_DEPTH);
            default:               wr_ok = 1'b1;
        endcase
    end

    always_comb begin
        o_entry.req      = req;
        o_entry.blank    = !in_raster;
        o_entry.pix_mode = pix_m;
        o_entry.colour   = colour_m;
        o_entry.value    = i_byte_value;
        o_entry.code     = i_glyph_code;
        o_entry.bitpos   = t_lx[2:0];
        o_entry.cword    = i_colour_word;
        if (req == REQ_RENDER) begin
            o_entry.in_range = pix_m ? px_ok : t_ok;
            o_entry.addr     = pix_m ? px_idx[16:0] : 17'(t_idx);
            o_entry.line     = t_ly[2:0];
        end else begin
            o_entry.in_range = wr_ok;
            o_entry.addr     = i_store_address;
            o_entry.line     = i_glyph_line;
        end
    end

endmodule

// ===== hw/rtl/tpvr_queue.sv =====
// ----------------------------------------------------------------------------
// tpvr_queue
// Short flop-based queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tpvr_queue import tpvr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_qent  i_entry,
    input  logic   i_pop,
    output t_qent  o_head,
    output t_qstat o_stat
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_qent         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic [PW:0]   n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (PW+1)'(QUEUE_DEPTH));

endmodule

// ===== hw/rtl/tpvr_back.sv =====
// ----------------------------------------------------------------------------
// tpvr_back
// Executes beats in order through three memory stages (maps, glyphs,
// palette) and an output register; clears every store after reset.
// ----------------------------------------------------------------------------
module tpvr_back import tpvr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_qent       i_head,
    input  logic        i_head_valid,
    output logic        o_pop,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_busy
);

    logic              adv;
    logic              pop;
    logic              r_clearing;
    logic [PIX_AW-1:0] r_clr_addr;

    t_qent       r_a;
    t_qent       r_b;
    logic        r_a_valid;
    logic        r_b_valid;
    logic        r_c_valid;
    logic        r_c_blank;
    logic [7:0]  r_b_attr;
    logic [7:0]  r_b_pix;
    logic        r_out_valid;
    logic [23:0] r_out_rgb;

    logic [7:0]  pix_rd;
    logic [7:0]  char_rd;
    logic [7:0]  attr_rd;
    logic        tv_rd;
    logic [7:0]  tile_rd;
    logic [7:0]  font_rd;
    logic [23:0] pal_rd;

    logic [7:0]  a_ch;
    logic [7:0]  a_attr;
    logic [7:0]  a_pix;
    logic [7:0]  b_bits;
    logic        b_on;
    logic        b_swap;
    logic [7:0]  b_fg;
    logic [7:0]  b_idx;

    // write ports, muxed between the clearing pass and normal traffic
    logic                pix_we;
    logic [PIX_AW-1:0]   pix_waddr;
    logic                char_we;
    logic                attr_we;
    logic [MAP_AW-1:0]   map_waddr;
    logic [7:0]          map_wdata;
    logic [7:0]          pix_wdata;
    logic                tv_we;
    logic [CODE_AW-1:0]  tv_waddr;
    logic                tv_wdata;
    logic                tile_we;
    logic                font_we;
    logic [GLYPH_AW-1:0] glyph_waddr;
    logic [7:0]          glyph_wdata;
    logic                pal_we;
    logic [CODE_AW-1:0]  pal_waddr;
    logic [23:0]         pal_wdata;

    assign adv = !r_out_valid || !i_stall;
    assign pop = adv && i_head_valid && !r_clearing;

    always_comb begin
        if (r_clearing) begin
            pix_we      = 1'b1;
            pix_waddr   = r_clr_addr;
            pix_wdata   = '0;
            char_we     = r_clr_addr < PIX_AW'(MAP_DEPTH);
            attr_we     = r_clr_addr < PIX_AW'(MAP_DEPTH);
            map_waddr   = r_clr_addr[MAP_AW-1:0];
            map_wdata   = '0;
            tv_we       = r_clr_addr < PIX_AW'(TILE_COUNT);
            tv_waddr    = r_clr_addr[CODE_AW-1:0];
            tv_wdata    = 1'b0;
            tile_we     = r_clr_addr < PIX_AW'(GLYPH_DEPTH);
            font_we     = r_clr_addr < PIX_AW'(GLYPH_DEPTH);
            glyph_waddr = r_clr_addr[GLYPH_AW-1:0];
            glyph_wdata = '0;
            pal_we      = r_clr_addr < PIX_AW'(PAL_DEPTH);
            pal_waddr   = r_clr_addr[CODE_AW-1:0];
            pal_wdata   = '0;
        end else begin
            pix_we      = pop && (i_head.req == REQ_FB) && i_head.in_range;
            pix_waddr   = i_head.addr;
            pix_wdata   = i_head.value;
            char_we     = pop && (i_head.req == REQ_CHAR) && i_head.in_range;
            attr_we     = pop && (i_head.req == REQ_ATTR) && i_head.in_range;
            map_waddr   = i_head.addr[MAP_AW-1:0];
            map_wdata   = i_head.value;
            tv_we       = adv && r_a_valid && (r_a.req == REQ_TILE_FLAG);
            tv_waddr    = r_a.code;
            tv_wdata    = r_a.value[0];
            tile_we     = adv && r_a_valid && (r_a.req == REQ_TILE_ROW);
            font_we     = adv && r_a_valid && (r_a.req == REQ_FONT);
            glyph_waddr = {r_a.code, r_a.line};
            glyph_wdata = r_a.value;
            pal_we      = adv && r_b_valid && (r_b.req == REQ_PALETTE);
            pal_waddr   = r_b.code;
            pal_wdata   = r_b.cword;
        end
    end

    // stage A: framebuffer and character maps
    tpvr_ram #(.WIDTH(8), .DEPTH(PIX_DEPTH)) u_pix (
        .i_clk   (i_clk),
        .i_we    (pix_we),
        .i_waddr (pix_waddr),
        .i_wdata (pix_wdata),
        .i_re    (adv),
        .i_raddr (i_head.addr),
        .o_rdata (pix_rd)
    );

    tpvr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_char (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (adv),
        .i_raddr (i_head.addr[MAP_AW-1:0]),
        .o_rdata (char_rd)
    );

    tpvr_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_attr (
        .i_clk   (i_clk),
        .i_we    (attr_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_re    (adv),
        .i_raddr (i_head.addr[MAP_AW-1:0]),
        .o_rdata (attr_rd)
    );

    assign a_ch   = r_a.in_range ? char_rd : 8'd0;
    assign a_attr = r_a.in_range ? attr_rd : 8'd0;
    assign a_pix  = r_a.in_range ? pix_rd  : 8'd0;

    // stage B: user tiles and font
    tpvr_ram #(.WIDTH(1), .DEPTH(TILE_COUNT)) u_tile_flag (
        .i_clk   (i_clk),
        .i_we    (tv_we),
        .i_waddr (tv_waddr),
        .i_wdata (tv_wdata),
        .i_re    (adv),
        .i_raddr (a_ch),
        .o_rdata (tv_rd)
    );

    tpvr_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_tile_rows (
        .i_clk   (i_clk),
        .i_we    (tile_we),
        .i_waddr (glyph_waddr),
        .i_wdata (glyph_wdata),
        .i_re    (adv),
        .i_raddr ({a_ch, r_a.line}),
        .o_rdata (tile_rd)
    );

    tpvr_ram #(.WIDTH(8), .DEPTH(GLYPH_DEPTH)) u_font (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (glyph_waddr),
        .i_wdata (glyph_wdata),
        .i_re    (adv),
        .i_raddr ({a_ch, r_a.line}),
        .o_rdata (font_rd)
    );

    assign b_bits = tv_rd ? tile_rd : font_rd;
    assign b_on   = b_bits[r_b.bitpos];
    assign b_swap = (r_b_attr & ATTR_SWAP) != 8'd0;
    assign b_fg   = r_b.colour ? (r_b_attr & ATTR_FG_MASK) + 8'd1 : 8'd1;
    // background is entry zero; the swap bit flips which one a set bit picks
    assign b_idx  = r_b.pix_mode ? r_b_pix : ((b_on != b_swap) ? b_fg : 8'd0);

    // stage C: palette
    tpvr_ram #(.WIDTH(24), .DEPTH(PAL_DEPTH)) u_pal (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (pal_waddr),
        .i_wdata (pal_wdata),
        .i_re    (adv),
        .i_raddr (b_idx),
        .o_rdata (pal_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == PIX_AW'(PIX_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (adv) begin
                r_a_valid   <= pop;
                r_b_valid   <= r_a_valid;
                // only renders carry on toward the output
                r_c_valid   <= r_b_valid && (r_b.req == REQ_RENDER);
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a       <= i_head;
            r_b       <= r_a;
            r_b_attr  <= a_attr;
            r_b_pix   <= a_pix;
            r_c_blank <= r_b.blank;
            r_out_rgb <= r_c_blank ? 24'd0 : pal_rd;
        end
    end

    assign o_pop   = pop;
    assign o_valid = r_out_valid;
    assign o_red   = r_out_rgb[23:16];
    assign o_green = r_out_rgb[15:8];
    assign o_blue  = r_out_rgb[7:0];
    assign o_busy  = r_clearing;

endmodule

// ===== test/render_checker.sv =====
// ----------------------------------------------------------------------------
// render_checker
// Watches the request, pixel and register channels of the video renderer,
// keeps its own copy of every store and of display_mode, predicts the colour
// of each accepted render beat and compares it with the returned pixel.
// ----------------------------------------------------------------------------
module render_checker import tpvr_pkg::*; #(
    parameter int OUT_WIDTH  = 640,
    parameter int FB_COLS    = 320,
    parameter int OUT_HEIGHT = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_req_valid,
    input  logic        i_req_stall,
    input  logic [2:0]  i_req_type,
    input  logic [9:0]  i_pos_x,
    input  logic [8:0]  i_pos_y,
    input  logic [16:0] i_store_address,
    input  logic [7:0]  i_byte_value,
    input  logic [7:0]  i_glyph_code,
    input  logic [2:0]  i_glyph_line,
    input  logic [23:0] i_colour_word,

    input  logic        i_pix_valid,
    input  logic        i_pix_stall,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,

    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,

    output int          o_error_count,
    output int          o_pixels_pending,
    output int          o_pixels_checked
);

    logic [7:0]  fb_mem        [PIX_DEPTH];
    logic [7:0]  char_mem      [MAP_DEPTH];
    logic [7:0]  attr_mem      [MAP_DEPTH];
    logic [7:0]  tile_mem      [GLYPH_DEPTH];
    logic        tile_flag_mem [TILE_COUNT];
    logic [7:0]  font_mem      [GLYPH_DEPTH];
    logic [23:0] pal_mem       [PAL_DEPTH];
    logic [2:0]  shown_mode;

    logic [23:0] pending_rgb [$];
    int errors  = 0;
    int checked = 0;

    function automatic void check_byte(string what, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            if (errors < 10)
                $display("render_checker: %s expected %02h got %02h (after %0d pixels)",
                         what, want, got, checked);
            errors++;
        end
    endfunction

    function automatic logic [23:0] predict_pixel(logic [9:0] x, logic [8:0] y);
        int lx, ly, idx, cols, scale, sub, bitpos;
        logic [7:0] ci, ch, attr, glyph, fg, bg, swap;
        logic wide, colour;
        if (x >= OUT_WIDTH || y >= OUT_HEIGHT)
            return 24'h0;
        if (shown_mode == MODE_PIXEL) begin
            lx  = x / 2;
            ly  = y / 2;
            idx = ly * FB_COLS + lx;
            ci  = (lx < FB_COLS && idx < PIX_DEPTH) ? fb_mem[idx] : 8'h00;
            return pal_mem[ci];
        end
        // modes above text80 colour fall back to text40 mono
        wide   = (shown_mode == MODE_T80_MONO || shown_mode == MODE_T80_COLOUR);
        colour = (shown_mode == MODE_T40_COLOUR || shown_mode == MODE_T80_COLOUR);
        cols   = wide ? int'(COLS_WIDE) : int'(COLS_NARROW);
        scale  = wide ? 1 : 2;
        lx     = x / scale;
        ly     = y / scale;
        idx    = (ly / 8) * cols + lx / 8;
        sub    = ly % 8;
        bitpos = lx % 8;
        ch     = 8'h00;
        attr   = 8'h00;
        if (lx / 8 < cols && idx < MAP_DEPTH) begin
            ch   = char_mem[idx];
            attr = attr_mem[idx];
        end
        glyph = tile_flag_mem[ch] ? tile_mem[ch * 8 + sub] : font_mem[ch * 8 + sub];
        fg    = colour ? (attr & ATTR_FG_MASK) + 8'd1 : 8'd1;
        bg    = 8'h00;
        if ((attr & ATTR_SWAP) != 8'h00) begin
            swap = fg;
            fg   = bg;
            bg   = swap;
        end
        return pal_mem[glyph[bitpos] ? fg : bg];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [23:0] want;
        if (!i_rst_n) begin
            foreach (fb_mem[i])        fb_mem[i] = 8'h00;
            foreach (char_mem[i])      char_mem[i] = 8'h00;
            foreach (attr_mem[i])      attr_mem[i] = 8'h00;
            foreach (tile_mem[i])      tile_mem[i] = 8'h00;
            foreach (tile_flag_mem[i]) tile_flag_mem[i] = 1'b0;
            foreach (font_mem[i])      font_mem[i] = 8'h00;
            foreach (pal_mem[i])       pal_mem[i] = 24'h0;
            shown_mode = MODE_T40_MONO;
            pending_rgb.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_IDX_MODE) begin
                if (i_pwrite)
                    shown_mode = i_pwdata[2:0];
                else
                    check_byte("display_mode readback", {5'd0, shown_mode},
                               {5'd0, i_prdata[2:0]});
            end

            if (i_pix_valid && !i_pix_stall) begin
                if (pending_rgb.size() == 0) begin
                    if (errors < 10)
                        $display("render_checker: pixel %02h%02h%02h with no render waiting",
                                 i_red, i_green, i_blue);
                    errors++;
                end else begin
                    want = pending_rgb.pop_front();
                    check_byte("red", want[23:16], i_red);
                    check_byte("green", want[15:8], i_green);
                    check_byte("blue", want[7:0], i_blue);
                    checked++;
                end
            end

            if (i_req_valid && !i_req_stall) begin
                case (t_req'(i_req_type))
                    REQ_RENDER:
                        pending_rgb.push_back(predict_pixel(i_pos_x, i_pos_y));
                    REQ_FB:
                        if (i_store_address < PIX_DEPTH)
                            fb_mem[i_store_address] = i_byte_value;
                    REQ_CHAR:
                        if (i_store_address < MAP_DEPTH)
                            char_mem[i_store_address] = i_byte_value;
                    REQ_ATTR:
                        if (i_store_address < MAP_DEPTH)
                            attr_mem[i_store_address] = i_byte_value;
                    REQ_TILE_ROW:
                        tile_mem[{i_glyph_code, i_glyph_line}] = i_byte_value;
                    REQ_TILE_FLAG:
                        tile_flag_mem[i_glyph_code] = i_byte_value[0];
                    REQ_FONT:
                        font_mem[{i_glyph_code, i_glyph_line}] = i_byte_value;
                    default:
                        pal_mem[i_glyph_code] = i_colour_word;
                endcase
            end
        end
        o_error_count    <= errors;
        o_pixels_pending <= pending_rgb.size();
        o_pixels_checked <= checked;
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives the video renderer with directed and random store and render beats
// across all display modes, with random gaps and output stalls; a checker
// beside the block predicts every pixel and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top import tpvr_pkg::*;;

    localparam int OUT_W       = 640;
    localparam int FB_W        = 320;
    localparam int OUT_H       = 480;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_BEATS = 130;
    localparam int SETTLE      = 12;

    localparam logic [2:0] MODE_REG_ADDR = 3'd0;
    localparam logic [2:0] MODE_SPARE_A  = 3'd5;
    localparam logic [2:0] MODE_SPARE_B  = 3'd6;
    localparam logic [2:0] MODE_SPARE_C  = 3'd7;

    typedef struct packed {
        t_req        req;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [16:0] addr;
        logic [7:0]  value;
        logic [7:0]  code;
        logic [2:0]  line;
        logic [23:0] cword;
    } t_req_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [2:0]  i_req_type = '0;
    logic [9:0]  i_pos_x = '0;
    logic [8:0]  i_pos_y = '0;
    logic [16:0] i_store_address = '0;
    logic [7:0]  i_byte_value = '0;
    logic [7:0]  i_glyph_code = '0;
    logic [2:0]  i_glyph_line = '0;
    logic [23:0] i_colour_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red, o_green, o_blue;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int error_count, pixels_pending, pixels_checked;
    int cycle_count = 0;
    int beats_sent = 0;
    int renders_sent = 0;
    int modes_set = 0;
    int stall_run = 0;
    logic calm = 1'b0;
    logic [2:0] cur_mode = MODE_T40_MONO;

    always #4 i_clk = ~i_clk;

    text_and_pixel_video_renderer #(
        .OUT_WIDTH (OUT_W),
        .FB_COLS   (FB_W),
        .OUT_HEIGHT(OUT_H)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_store_address(i_store_address),
        .i_byte_value   (i_byte_value),
        .i_glyph_code   (i_glyph_code),
        .i_glyph_line   (i_glyph_line),
        .i_colour_word  (i_colour_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    render_checker #(
        .OUT_WIDTH (OUT_W),
        .FB_COLS   (FB_W),
        .OUT_HEIGHT(OUT_H)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_type      (i_req_type),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_store_address (i_store_address),
        .i_byte_value    (i_byte_value),
        .i_glyph_code    (i_glyph_code),
        .i_glyph_line    (i_glyph_line),
        .i_colour_word   (i_colour_word),
        .i_pix_valid     (o_valid),
        .i_pix_stall     (i_stall),
        .i_red           (o_red),
        .i_green         (o_green),
        .i_blue          (o_blue),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_error_count   (error_count),
        .o_pixels_pending(pixels_pending),
        .o_pixels_checked(pixels_checked)
    );

    // output stall in random bursts
    always @(posedge i_clk) begin
        if (calm || !i_rst_n) begin
            stall_run = 0;
            i_stall <= 1'b0;
        end else if (stall_run > 0) begin
            stall_run--;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_run = $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: timed out after %0d cycles", cycle_count);
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic t_req_beat random_beat(t_req rq);
        t_req_beat b;
        b.req   = rq;
        b.x     = 10'($urandom);
        b.y     = 9'($urandom);
        b.addr  = 17'($urandom);
        b.value = 8'($urandom);
        b.code  = 8'($urandom);
        b.line  = 3'($urandom);
        b.cword = 24'($urandom);
        return b;
    endfunction

    task automatic send(t_req_beat b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= b.req;
        i_pos_x         <= b.x;
        i_pos_y         <= b.y;
        i_store_address <= b.addr;
        i_byte_value    <= b.value;
        i_glyph_code    <= b.code;
        i_glyph_line    <= b.line;
        i_colour_word   <= b.cword;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
        if (b.req == REQ_RENDER)
            renders_sent++;
    endtask

    // fields that the request type does not use stay random
    task automatic store(t_req rq, int addr, int value, int code, int line, int cword);
        t_req_beat b;
        b = random_beat(rq);
        if (rq != REQ_PALETTE)
            b.value = value[7:0];
        case (rq)
            REQ_FB, REQ_CHAR, REQ_ATTR:
                b.addr = addr[16:0];
            REQ_TILE_ROW, REQ_FONT: begin
                b.code = code[7:0];
                b.line = line[2:0];
            end
            REQ_TILE_FLAG:
                b.code = code[7:0];
            REQ_PALETTE: begin
                b.code  = code[7:0];
                b.cword = cword[23:0];
            end
            default: ;
        endcase
        send(b);
    endtask

    task automatic render_at(int x, int y);
        t_req_beat b;
        b = random_beat(REQ_RENDER);
        b.x = x[9:0];
        b.y = y[8:0];
        send(b);
    endtask

    // fill one character cell with glyph, attribute and maybe palette, then sample it
    task automatic cell_burst();
        int cols, rows, scale, col, row, idx;
        logic [7:0] ch;
        logic wide, use_tile;
        wide     = (cur_mode == MODE_T80_MONO || cur_mode == MODE_T80_COLOUR);
        cols     = wide ? 80 : 40;
        rows     = wide ? 60 : 30;
        scale    = wide ? 1 : 2;
        col      = $urandom_range(0, cols - 1);
        row      = $urandom_range(0, rows - 1);
        idx      = row * cols + col;
        ch       = 8'($urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 255));
        use_tile = $urandom_range(0, 2) == 0;
        store(REQ_CHAR, idx, ch, 0, 0, 0);
        store(REQ_ATTR, idx, $urandom_range(0, 255), 0, 0, 0);
        if (use_tile)
            store(REQ_TILE_FLAG, 0, $urandom_range(0, 255), ch, 0, 0);
        repeat ($urandom_range(1, 3))
            store(use_tile ? REQ_TILE_ROW : REQ_FONT, 0, $urandom_range(0, 255), ch,
                  $urandom_range(0, 7), 0);
        if ($urandom_range(0, 1))
            store(REQ_PALETTE, 0, 0, $urandom_range(0, 8), 0, $urandom);
        repeat ($urandom_range(2, 4))
            render_at((col * 8 + $urandom_range(0, 7)) * scale + $urandom_range(0, scale - 1),
                      (row * 8 + $urandom_range(0, 7)) * scale + $urandom_range(0, scale - 1));
    endtask

    task automatic fb_burst();
        int lx, ly;
        logic [7:0] v;
        lx = $urandom_range(0, FB_W - 1);
        ly = $urandom_range(0, OUT_H / 2 - 1);
        v  = 8'($urandom);
        store(REQ_FB, ly * FB_W + lx, v, 0, 0, 0);
        if ($urandom_range(0, 2) != 0)
            store(REQ_PALETTE, 0, 0, v, 0, $urandom);
        repeat ($urandom_range(1, 3))
            render_at(2 * lx + $urandom_range(0, 1), 2 * ly + $urandom_range(0, 1));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 3))
            send(random_beat(t_req'($urandom_range(0, 7))));
    endtask

    // let the pipeline empty, with no gaps or stalls, before a register access
    task automatic drain();
        logic was_calm;
        was_calm = calm;
        calm     = 1'b1;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        calm = was_calm;
    endtask

    // write display_mode, then read it back for the checker
    task automatic set_mode(logic [2:0] m);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MODE_REG_ADDR;
        pwdata  <= {29'd0, m};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        cur_mode = m;
        modes_set++;
    endtask

    initial begin : stimulus
        logic [2:0] phase_modes [10];
        int phase_start, pick;
        phase_modes = '{MODE_PIXEL, MODE_T40_COLOUR, MODE_T80_MONO, MODE_T80_COLOUR,
                        MODE_SPARE_C, MODE_SPARE_A, MODE_PIXEL, MODE_SPARE_B,
                        MODE_T80_COLOUR, MODE_T40_MONO};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset mode text40 mono, blank stores, glyph source and swap
        render_at(0, 0);
        store(REQ_PALETTE, 0, 0, 0, 0, 24'h123456);
        store(REQ_PALETTE, 0, 0, 1, 0, 24'hABCDEF);
        store(REQ_PALETTE, 0, 0, 255, 0, 24'hFFFFFF);
        store(REQ_FONT, 0, 8'h01, 0, 0, 0);
        render_at(0, 0);
        render_at(2, 0);
        render_at(1023, 511);
        render_at(OUT_W, 0);
        render_at(0, OUT_H);
        store(REQ_CHAR, 0, 8'hFF, 0, 0, 0);
        store(REQ_ATTR, 0, 8'h87, 0, 0, 0);
        store(REQ_FONT, 0, 8'hFE, 255, 0, 0);
        render_at(0, 0);
        store(REQ_TILE_ROW, 0, 8'h01, 255, 0, 0);
        store(REQ_TILE_FLAG, 0, 8'hFF, 255, 0, 0);
        render_at(0, 0);
        store(REQ_TILE_FLAG, 0, 8'hFE, 255, 0, 0);
        render_at(1, 1);
        store(REQ_CHAR, MAP_DEPTH, 8'h55, 0, 0, 0);
        store(REQ_FB, PIX_DEPTH, 8'h55, 0, 0, 0);
        store(REQ_FB, PIX_DEPTH - 1, 8'hFF, 0, 0, 0);
        store(REQ_ATTR, 131071, 8'hFF, 0, 0, 0);
        store(REQ_FONT, 0, 8'h80, 255, 7, 0);
        render_at(OUT_W - 1, OUT_H - 1);
        drain();

        foreach (phase_modes[p]) begin
            if (p == 9)
                calm = 1'b1;
            set_mode(phase_modes[p]);
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    noise_burst();
                else if (pick == 9)
                    if (cur_mode == MODE_PIXEL) cell_burst(); else fb_burst();
                else if (cur_mode == MODE_PIXEL)
                    fb_burst();
                else
                    cell_burst();
            end
            drain();
        end

        $display("tb_top: %0d beats sent, %0d of them renders, over %0d mode settings",
                 beats_sent, renders_sent, modes_set);
        $display("tb_top: %0d pixels compared, %0d mismatches, %0d renders unanswered",
                 pixels_checked, error_count, pixels_pending);
        if (error_count == 0 && pixels_pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tpvr_pkg.sv
hw/rtl/tpvr_ram.sv
hw/rtl/tpvr_front.sv
hw/rtl/tpvr_queue.sv
hw/rtl/tpvr_back.sv
hw/rtl/text_and_pixel_video_renderer.sv
test/render_checker.sv
test/tb_top.sv
